[sv/rrp_pkg.sv]
// Shared types and constants for the request parser.
`default_nettype none
package rrp_pkg;

  localparam int LINE_W  = 21;
  localparam int COUNT_W = 21;
  localparam int BULK_W  = 30;
  localparam int CFG_W   = 30;
  localparam int NUM_W   = 64;

  localparam logic [LINE_W-1:0]  MAX_LINE_RST = 21'd65536;
  localparam logic [COUNT_W-1:0] MAX_ARG_RST  = 21'd1048576;
  localparam logic [BULK_W-1:0]  MAX_BULK_RST = 30'd536870912;

  localparam logic [1:0] CFG_MAX_LINE = 2'd0;
  localparam logic [1:0] CFG_MAX_ARG  = 2'd1;
  localparam logic [1:0] CFG_MAX_BULK = 2'd2;

  localparam logic [1:0] EV_DATA    = 2'd0;
  localparam logic [1:0] EV_ARG_END = 2'd1;
  localparam logic [1:0] EV_CMD_END = 2'd2;
  localparam logic [1:0] EV_ERROR   = 2'd3;

  localparam logic [2:0] ERR_INLINE_LONG = 3'd0;
  localparam logic [2:0] ERR_COUNT_LONG  = 3'd1;
  localparam logic [2:0] ERR_BAD_COUNT   = 3'd2;
  localparam logic [2:0] ERR_NO_DOLLAR   = 3'd3;
  localparam logic [2:0] ERR_BAD_LENGTH  = 3'd4;
  localparam logic [2:0] ERR_LEN_LONG    = 3'd5;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // digit tracker: none, single zero, nonzero lead, invalid
  localparam logic [1:0] DIG_NONE    = 2'd0;
  localparam logic [1:0] DIG_ZERO    = 2'd1;
  localparam logic [1:0] DIG_NUM     = 2'd2;
  localparam logic [1:0] DIG_INVALID = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         data;
    logic [COUNT_W-1:0] total;
    logic [2:0]         code;
    logic               last;
  } result_t;

  function automatic result_t mk_result(input logic [1:0] kind, input logic [7:0] data,
                                        input logic [COUNT_W-1:0] total,
                                        input logic [2:0] code);
    result_t r;
    r.kind  = kind;
    r.data  = data;
    r.total = total;
    r.code  = code;
    r.last  = 1'b0;
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/resp_request_parser.sv]
// Top level of the streaming request parser: byte decoder and result queue.
//
// Usage:
//   Input channel in_valid/in_stall/in_byte carries one request byte per item.
//   Result channel out_valid/out_stall carries one event per item: data byte,
//   argument end, command end (with argument count) or protocol error.
//   cfg_we/cfg_index/cfg_data write the line, count and bulk limits; the
//   user must write them only while idle; the block does not enforce it.
// Throughput: one byte per cycle while the receiver takes one result per
//   cycle; a byte that yields two results needs the result side for both of
//   them. A three-entry result queue lets a byte be taken while one result
//   still waits, so the input stalls only when two or more stay queued.
// Reset (synchronous, rst_n low): parser returns to idle, limits take their
//   defaults, the queue empties and any latched error clears.
// Receiver stall: queued results hold; the input stalls once the queue could
//   not absorb two more results.
// A protocol error is reported once and then all further bytes are consumed
// without results until reset.
`default_nettype none
module resp_request_parser (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [7:0]                   in_byte,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [1:0]                   out_event_kind,
  output logic [7:0]                   out_data_byte,
  output logic [rrp_pkg::COUNT_W-1:0]  out_arg_total,
  output logic [2:0]                   out_error_code,
  output logic                         out_last,
  input  wire                          cfg_we,
  input  wire  [1:0]                   cfg_index,
  input  wire  [rrp_pkg::CFG_W-1:0]    cfg_data
);

  localparam logic [3:0] M_IDLE       = 4'd0;
  localparam logic [3:0] M_INLINE     = 4'd1;
  localparam logic [3:0] M_COUNT      = 4'd2;
  localparam logic [3:0] M_LEN_FIRST  = 4'd3;
  localparam logic [3:0] M_LEN_DIGITS = 4'd4;
  localparam logic [3:0] M_LEN_BAD    = 4'd5;
  localparam logic [3:0] M_BULK       = 4'd6;
  localparam logic [3:0] M_TRAIL1     = 4'd7;
  localparam logic [3:0] M_TRAIL2     = 4'd8;

  localparam int LW = rrp_pkg::LINE_W;
  localparam int CW = rrp_pkg::COUNT_W;
  localparam int BW = rrp_pkg::BULK_W;
  localparam int NW = rrp_pkg::NUM_W;

  logic [LW-1:0] max_line_r;
  logic [CW-1:0] max_arg_r;
  logic [BW-1:0] max_bulk_r;

  logic [3:0]    mode_r, mode_nxt;
  logic [NW-1:0] acc_r, acc_nxt;
  logic          neg_r, neg_nxt;
  logic [1:0]    dig_r, dig_nxt;
  logic [CW-1:0] args_rem_r, args_rem_nxt;
  logic [BW-1:0] bulk_rem_r, bulk_rem_nxt;
  logic [LW-1:0] line_len_r, line_len_nxt;
  logic          held_r, held_nxt;
  logic          tok_r, tok_nxt;
  logic [CW-1:0] done_r, done_nxt;
  logic          err_r, err_nxt;

  rrp_pkg::result_t q_r [3];
  rrp_pkg::result_t q_nxt [3];
  logic [1:0]       cnt_r, cnt_nxt;

  rrp_pkg::result_t res [2];
  logic [1:0]       n;
  logic             clr;

  logic             accept, pop;
  logic [1:0]       cnt_p;

  logic             is_idle;
  logic             e_held, e_tok;
  logic [CW-1:0]    e_done;
  logic [LW-1:0]    e_len;
  logic             grow_ok;
  logic [LW-1:0]    len_inc;
  logic             tok_c;
  logic [CW-1:0]    done_c;
  logic [BW-1:0]    bulk_dec;
  logic [CW-1:0]    rem_dec;

  logic             is_digit;
  logic [3:0]       digit;
  logic [NW+3:0]    prod;
  logic [NW-1:0]    f_acc;
  logic             f_neg;
  logic [1:0]       f_dig;
  logic             num_ok;
  logic [NW-1:0]    len_val;

  // digit accumulation from the current number state
  always_comb begin
    is_digit = (in_byte >= rrp_pkg::CH_ZERO) && (in_byte <= rrp_pkg::CH_NINE);
    digit    = 4'(in_byte - rrp_pkg::CH_ZERO);
    prod     = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + (NW+4)'(digit);
    f_acc    = acc_r;
    f_neg    = neg_r;
    f_dig    = dig_r;
    if (dig_r != rrp_pkg::DIG_INVALID) begin
      if (is_digit) begin
        unique case (dig_r)
          rrp_pkg::DIG_NONE: begin
            if (digit == 4'd0) begin
              f_dig = neg_r ? rrp_pkg::DIG_INVALID : rrp_pkg::DIG_ZERO;
            end else begin
              f_dig = rrp_pkg::DIG_NUM;
              f_acc = NW'(digit);
            end
          end
          rrp_pkg::DIG_ZERO: f_dig = rrp_pkg::DIG_INVALID;
          default: begin
            if (prod[NW+3:NW] != 4'd0) begin
              f_dig = rrp_pkg::DIG_INVALID;
            end else begin
              f_acc = prod[NW-1:0];
            end
          end
        endcase
      end else if (in_byte == rrp_pkg::CH_MINUS && dig_r == rrp_pkg::DIG_NONE && !neg_r) begin
        f_neg = 1'b1;
      end else begin
        f_dig = rrp_pkg::DIG_INVALID;
      end
    end
    if (dig_r == rrp_pkg::DIG_ZERO) begin
      num_ok = 1'b1;
    end else if (dig_r == rrp_pkg::DIG_NUM) begin
      num_ok = neg_r ? (!acc_r[NW-1] || acc_r[NW-2:0] == '0) : !acc_r[NW-1];
    end else begin
      num_ok = 1'b0;
    end
    len_val = (dig_r == rrp_pkg::DIG_ZERO) ? '0 : acc_r;
  end

  always_comb begin
    mode_nxt     = mode_r;
    acc_nxt      = acc_r;
    neg_nxt      = neg_r;
    dig_nxt      = dig_r;
    args_rem_nxt = args_rem_r;
    bulk_rem_nxt = bulk_rem_r;
    line_len_nxt = line_len_r;
    held_nxt     = held_r;
    tok_nxt      = tok_r;
    done_nxt     = done_r;
    err_nxt      = err_r;
    res[0]       = '0;
    res[1]       = '0;
    n            = 2'd0;
    clr          = 1'b0;
    tok_c        = 1'b0;
    done_c       = done_r;

    is_idle  = !(mode_r == M_INLINE || mode_r == M_COUNT || mode_r == M_LEN_FIRST ||
                 mode_r == M_LEN_DIGITS || mode_r == M_LEN_BAD || mode_r == M_BULK ||
                 mode_r == M_TRAIL1 || mode_r == M_TRAIL2);
    e_held   = is_idle ? 1'b0 : held_r;
    e_tok    = is_idle ? 1'b0 : tok_r;
    e_done   = is_idle ? '0 : done_r;
    e_len    = is_idle ? '0 : line_len_r;
    grow_ok  = e_len < max_line_r;
    len_inc  = e_len + LW'(1);
    bulk_dec = (bulk_rem_r != '0) ? bulk_rem_r - BW'(1) : bulk_rem_r;
    rem_dec  = (args_rem_r != '0) ? args_rem_r - CW'(1) : args_rem_r;

    if (!err_r) begin
      unique case (mode_r)
        M_COUNT, M_LEN_DIGITS, M_LEN_BAD: begin
          if (held_r) begin
            held_nxt = 1'b0;
            if (mode_r == M_COUNT) begin
              if (!num_ok) begin
                err_nxt = 1'b1;
                res[n[0]] = rrp_pkg::mk_result(rrp_pkg::EV_ERROR, 8'h00, '0,
                                               rrp_pkg::ERR_BAD_COUNT);
                n = n + 2'd1;
              end else if (dig_r == rrp_pkg::DIG_ZERO || neg_r) begin
                clr = 1'b1;
              end else if (acc_r > NW'(max_arg_r)) begin
                err_nxt = 1'b1;
                res[n[0]] = rrp_pkg::mk_result(rrp_pkg::EV_ERROR, 8'h00, '0,
                                               rrp_pkg::ERR_BAD_COUNT);
                n = n + 2'd1;
              end else begin
                args_rem_nxt = acc_r[CW-1:0];
                done_nxt     = '0;
                line_len_nxt = '0;
                acc_nxt      = '0;
                neg_nxt      = 1'b0;
                dig_nxt      = rrp_pkg::DIG_NONE;
                mode_nxt     = M_LEN_FIRST;
              end
            end else if (mode_r == M_LEN_BAD) begin
              err_nxt = 1'b1;
              res[n[0]] = rrp_pkg::mk_result(rrp_pkg::EV_ERROR, 8'h00, '0,
                                             rrp_pkg::ERR_NO_DOLLAR);
              n = n + 2'd1;
            end else if (!num_ok || (dig_r == rrp_pkg::DIG_NUM && neg_r) ||
                         len_val > NW'(max_bulk_r)) begin
              err_nxt = 1'b1;
              res[n[0]] = rrp_pkg::mk_result(rrp_pkg::EV_ERROR, 8'h00, '0,
                                             rrp_pkg::ERR_BAD_LENGTH);
              n = n + 2'd1;
            end else begin
              bulk_rem_nxt = len_val[BW-1:0];
              line_len_nxt = '0;
              acc_nxt      = '0;
              neg_nxt      = 1'b0;
              dig_nxt      = rrp_pkg::DIG_NONE;
              mode_nxt     = (len_val != '0) ? M_BULK : M_TRAIL1;
            end
          end else if (in_byte == rrp_pkg::CH_CR) begin
            held_nxt = 1'b1;
          end else if (!grow_ok) begin
            err_nxt = 1'b1;
            res[n[0]] = rrp_pkg::mk_result(rrp_pkg::EV_ERROR, 8'h00, '0,
                                           (mode_r == M_COUNT) ? rrp_pkg::ERR_COUNT_LONG
                                                               : rrp_pkg::ERR_LEN_LONG);
            n = n + 2'd1;
          end else begin
            line_len_nxt = len_inc;
            if (mode_r != M_LEN_BAD) begin
              acc_nxt = f_acc;
              neg_nxt = f_neg;
              dig_nxt = f_dig;
            end
          end
        end
        M_LEN_FIRST: begin
          if (in_byte == rrp_pkg::CH_CR) begin
            held_nxt = 1'b1;
            mode_nxt = M_LEN_BAD;
          end else if (!grow_ok) begin
            err_nxt = 1'b1;
            res[n[0]] = rrp_pkg::mk_result(rrp_pkg::EV_ERROR, 8'h00, '0,
                                           rrp_pkg::ERR_LEN_LONG);
            n = n + 2'd1;
          end else begin
            line_len_nxt = len_inc;
            acc_nxt      = '0;
            neg_nxt      = 1'b0;
            dig_nxt      = rrp_pkg::DIG_NONE;
            mode_nxt     = (in_byte == rrp_pkg::CH_DOLLAR) ? M_LEN_DIGITS : M_LEN_BAD;
          end
        end
        M_BULK: begin
          res[n[0]] = rrp_pkg::mk_result(rrp_pkg::EV_DATA, in_byte, '0, 3'd0);
          n = n + 2'd1;
          bulk_rem_nxt = bulk_dec;
          if (bulk_dec == '0) begin
            mode_nxt = M_TRAIL1;
          end
        end
        M_TRAIL1: begin
          mode_nxt = M_TRAIL2;
        end
        M_TRAIL2: begin
          res[n[0]] = rrp_pkg::mk_result(rrp_pkg::EV_ARG_END, 8'h00, '0, 3'd0);
          n = n + 2'd1;
          done_c = done_r + CW'(1);
          done_nxt = done_c;
          args_rem_nxt = rem_dec;
          if (rem_dec == '0) begin
            res[n[0]] = rrp_pkg::mk_result(rrp_pkg::EV_CMD_END, 8'h00, done_c, 3'd0);
            n = n + 2'd1;
            clr = 1'b1;
          end else begin
            line_len_nxt = '0;
            mode_nxt     = M_LEN_FIRST;
          end
        end
        default: begin
          // idle and inline, with unused codes treated as idle
          if (is_idle) begin
            acc_nxt      = '0;
            neg_nxt      = 1'b0;
            dig_nxt      = rrp_pkg::DIG_NONE;
            args_rem_nxt = '0;
            bulk_rem_nxt = '0;
          end
          if (is_idle && in_byte == rrp_pkg::CH_STAR) begin
            held_nxt = 1'b0;
            tok_nxt  = 1'b0;
            done_nxt = '0;
            if (!grow_ok) begin
              err_nxt = 1'b1;
              res[n[0]] = rrp_pkg::mk_result(rrp_pkg::EV_ERROR, 8'h00, '0,
                                             rrp_pkg::ERR_COUNT_LONG);
              n = n + 2'd1;
            end else begin
              line_len_nxt = len_inc;
              mode_nxt     = M_COUNT;
            end
          end else begin
            mode_nxt = M_INLINE;
            tok_c    = e_tok;
            done_c   = e_done;
            if (e_held && in_byte == rrp_pkg::CH_LF) begin
              if (tok_c) begin
                res[n[0]] = rrp_pkg::mk_result(rrp_pkg::EV_ARG_END, 8'h00, '0, 3'd0);
                n = n + 2'd1;
                done_c = e_done + CW'(1);
              end
              if (done_c != '0) begin
                res[n[0]] = rrp_pkg::mk_result(rrp_pkg::EV_CMD_END, 8'h00, done_c, 3'd0);
                n = n + 2'd1;
              end
              clr = 1'b1;
            end else if (!grow_ok) begin
              err_nxt = 1'b1;
              res[n[0]] = rrp_pkg::mk_result(rrp_pkg::EV_ERROR, 8'h00, '0,
                                             rrp_pkg::ERR_INLINE_LONG);
              n = n + 2'd1;
            end else begin
              line_len_nxt = len_inc;
              held_nxt     = 1'b0;
              if (e_held) begin
                res[n[0]] = rrp_pkg::mk_result(rrp_pkg::EV_DATA, rrp_pkg::CH_CR, '0, 3'd0);
                n = n + 2'd1;
                tok_c = 1'b1;
              end
              if (in_byte == rrp_pkg::CH_CR) begin
                held_nxt = 1'b1;
              end else if (in_byte == rrp_pkg::CH_SPACE) begin
                if (tok_c) begin
                  res[n[0]] = rrp_pkg::mk_result(rrp_pkg::EV_ARG_END, 8'h00, '0, 3'd0);
                  n = n + 2'd1;
                  done_c = e_done + CW'(1);
                  tok_c  = 1'b0;
                end
              end else begin
                res[n[0]] = rrp_pkg::mk_result(rrp_pkg::EV_DATA, in_byte, '0, 3'd0);
                n = n + 2'd1;
                tok_c = 1'b1;
              end
              tok_nxt  = tok_c;
              done_nxt = done_c;
            end
          end
        end
      endcase
    end

    if (clr) begin
      mode_nxt     = M_IDLE;
      acc_nxt      = '0;
      neg_nxt      = 1'b0;
      dig_nxt      = rrp_pkg::DIG_NONE;
      args_rem_nxt = '0;
      bulk_rem_nxt = '0;
      line_len_nxt = '0;
      held_nxt     = 1'b0;
      tok_nxt      = 1'b0;
      done_nxt     = '0;
    end

    if (n == 2'd2) begin
      res[1].last = 1'b1;
    end else if (n == 2'd1) begin
      res[0].last = 1'b1;
    end
  end

  // result queue: entry 0 drives the output
  always_comb begin
    pop      = (cnt_r != 2'd0) && !out_stall;
    cnt_p    = cnt_r - {1'b0, pop};
    in_stall = cnt_p > 2'd1;
    accept   = in_valid && !in_stall;
    q_nxt[0] = pop ? q_r[1] : q_r[0];
    q_nxt[1] = pop ? q_r[2] : q_r[1];
    q_nxt[2] = q_r[2];
    cnt_nxt  = cnt_p;
    if (accept) begin
      if (n != 2'd0) begin
        q_nxt[cnt_p] = res[0];
      end
      if (n == 2'd2) begin
        q_nxt[cnt_p + 2'd1] = res[1];
      end
      cnt_nxt = cnt_p + n;
    end
  end

  assign out_valid      = cnt_r != 2'd0;
  assign out_event_kind = q_r[0].kind;
  assign out_data_byte  = q_r[0].data;
  assign out_arg_total  = q_r[0].total;
  assign out_error_code = q_r[0].code;
  assign out_last       = q_r[0].last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_line_r <= rrp_pkg::MAX_LINE_RST;
      max_arg_r  <= rrp_pkg::MAX_ARG_RST;
      max_bulk_r <= rrp_pkg::MAX_BULK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rrp_pkg::CFG_MAX_LINE: max_line_r <= cfg_data[LW-1:0];
        rrp_pkg::CFG_MAX_ARG:  max_arg_r  <= cfg_data[CW-1:0];
        rrp_pkg::CFG_MAX_BULK: max_bulk_r <= cfg_data[BW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= M_IDLE;
      acc_r      <= '0;
      neg_r      <= 1'b0;
      dig_r      <= rrp_pkg::DIG_NONE;
      args_rem_r <= '0;
      bulk_rem_r <= '0;
      line_len_r <= '0;
      held_r     <= 1'b0;
      tok_r      <= 1'b0;
      done_r     <= '0;
      err_r      <= 1'b0;
      cnt_r      <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (accept) begin
        mode_r     <= mode_nxt;
        acc_r      <= acc_nxt;
        neg_r      <= neg_nxt;
        dig_r      <= dig_nxt;
        args_rem_r <= args_rem_nxt;
        bulk_rem_r <= bulk_rem_nxt;
        line_len_r <= line_len_nxt;
        held_r     <= held_nxt;
        tok_r      <= tok_nxt;
        done_r     <= done_nxt;
        err_r      <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
    q_r[2] <= q_nxt[2];
  end

`ifndef SYNTH
  a_stall_needs_queue: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with an empty result queue");

  a_error_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && err_r) |=> (cnt_r <= $past(cnt_r)))
    else $error("results produced after a latched error");

  a_cmd_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_kind == rrp_pkg::EV_CMD_END) |-> out_last)
    else $error("command end not marked as final result of its byte");

  a_error_latched: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_kind == rrp_pkg::EV_ERROR) |-> (err_r && out_last))
    else $error("error result without latched error state");
`endif

endmodule
`default_nettype wire
